FILE: src/ifs_pkg.sv
// Shared types and constants for the island falloff shaper.
// Used by every module of the block; depends on nothing.
package ifs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SIDE_W    = 13;  // frame size register width
  localparam int POS_W     = 12;  // pixel position width
  localparam int MAX_SIDE  = 4096;

  // Q16.16 constants of the hyperboloid mode (C = 0.2)
  localparam logic [16:0] FX_ONE = 17'd65536;
  localparam logic [16:0] HYP_CQ = 17'd13107;  // round(0.2 * ONE)
  localparam logic [16:0] HYP_C2 = 17'd2621;   // round(CQ * CQ / ONE)
  localparam logic [15:0] HYP_K  = 16'd53726;  // isqrt((ONE + C2) * ONE) - CQ
  // ceil(2^49 / K): n * ONE / K becomes (n * HYP_RECIP) >> 33, exact for n < 2^17
  localparam logic [33:0] HYP_RECIP =
    34'(((64'd1 << 49) + 64'(HYP_K) - 64'd1) / 64'(HYP_K));

  localparam logic signed [31:0] HEIGHT_MAX = 32'sh7FFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef enum logic [2:0] {
    MODE_BUMP = 3'd0,
    MODE_EUCL = 3'd1,
    MODE_SQR  = 3'd2,
    MODE_HYP  = 3'd3,
    MODE_DIAG = 3'd4
  } dist_mode_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] height_in;
  } ifs_in_t;

  typedef struct packed {
    logic signed [31:0] height_out;
    logic               frame_end;
  } ifs_out_t;

  // effective configuration, sizes already clamped to 1..MAX_SIDE
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    dist_mode_t        mode;
  } ifs_cfg_t;

  // one shape request handed from front to back
  typedef struct packed {
    logic signed [31:0] height;
    logic signed [31:0] minimum;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               last;
  } ifs_job_t;

endpackage

FILE: src/ifs_front.sv
// Front end: accepts requests, tracks pixel position and frame minimum.
// Shape requests are pushed as jobs into the queue. Depends on ifs_pkg.
module ifs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifs_pkg::ifs_in_t  in_data,
  input  ifs_pkg::ifs_cfg_t cfg,
  input  logic              q_full,
  output logic              push_valid,
  output ifs_pkg::ifs_job_t push_data
);
  import ifs_pkg::*;

  logic [POS_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [POS_W-1:0]   col_e, row_e;
  logic signed [31:0] min_r, min_nxt;
  logic               last, accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // position clipped to the current frame size
  always_comb begin
    col_e = ({1'b0, col_r} >= cfg.width)  ? '0 : col_r;
    row_e = ({1'b0, row_r} >= cfg.height) ? '0 : row_r;
    last  = ({1'b0, col_e} == cfg.width - 1'b1) && ({1'b0, row_e} == cfg.height - 1'b1);
  end

  // next position and minimum
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    min_nxt = min_r;
    if (accept) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if ({1'b0, col_e} + 1'b1 >= cfg.width) begin
        col_nxt = '0;
        row_nxt = row_e + 1'b1;
      end else begin
        col_nxt = col_e + 1'b1;
        row_nxt = row_e;
      end
      if (!in_data.action) begin
        if ((col_e == '0 && row_e == '0) || in_data.height_in < min_r) begin
          min_nxt = in_data.height_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      min_r <= HEIGHT_MAX;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      min_r <= min_nxt;
    end
  end

  // shape request goes to the back end with the minimum held now
  assign push_valid        = accept && in_data.action;
  assign push_data.height  = in_data.height_in;
  assign push_data.minimum = min_r;
  assign push_data.col     = col_e;
  assign push_data.row     = row_e;
  assign push_data.last    = last;

endmodule

FILE: src/ifs_queue.sv
// Short job queue between front and back end.
// Four entries of ifs_job_t. Depends on ifs_pkg.
module ifs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  ifs_pkg::ifs_job_t push_data,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ifs_pkg::ifs_job_t pop_data
);
  import ifs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ifs_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_pop;

  assign full      = (cnt_r == (PTR_W + 1)'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_r];
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_valid) wr_r <= wr_r + 1'b1;
      if (do_pop)     rd_r <= rd_r + 1'b1;
      if (push_valid && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push_valid && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: src/ifs_back.sv
// Back end: centred coordinates, distance function and final blend.
// One shared restoring divider and one digit-serial square root. Depends on ifs_pkg.
module ifs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ifs_pkg::ifs_cfg_t cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  ifs_pkg::ifs_job_t pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ifs_pkg::ifs_out_t out_data
);
  import ifs_pkg::*;

  localparam int DIV_W = 34;
  localparam int SQ_W  = 34;
  localparam int SQ_STEPS = SQ_W / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVU, S_DIVV, S_SQR, S_DIST, S_BUMP, S_ROOT, S_HYPQ, S_MUL, S_SAT
  } state_t;

  state_t              state_r;
  ifs_job_t            job_r;
  logic [DIV_W-1:0]    div_num_r;
  logic [15:0]         div_rem_r, div_den_r;
  logic [5:0]          cnt_r;
  logic [11:0]         mag_v_r;
  logic                neg_u_r, neg_v_r;
  logic signed [17:0]  u_r, v_r;
  logic [16:0]         u2_r, v2_r, d_r;
  logic [33:0]         bump_r;
  logic [SQ_W-1:0]     sq_rad_r;
  logic [19:0]         sq_rem_r;
  logic [16:0]         sq_root_r;
  logic [49:0]         hyp_prod_r;
  logic signed [51:0]  prod_r;
  logic                out_valid_r;
  ifs_out_t            out_r;

  // divider and square root step logic, centred offsets, squares and final blend
  logic [16:0]         div_sh;
  logic                div_ge;
  logic [19:0]         sq_sh, sq_trial;
  logic                sq_ge;
  logic signed [13:0]  off_u, off_v;
  logic [11:0]         mag_u, mag_v;
  logic signed [17:0]  q_s;
  logic signed [35:0]  uu, vv;
  logic [17:0]         r2;
  logic [16:0]         au, av, n_hyp;
  logic [16:0]         om_u, om_v;
  logic signed [32:0]  diff;
  logic signed [18:0]  one_md;
  logic signed [51:0]  shifted;
  logic signed [52:0]  blended;
  logic signed [31:0]  sat_val;

  always_comb begin
    div_sh   = {div_rem_r, div_num_r[DIV_W-1]};
    div_ge   = div_sh >= {1'b0, div_den_r};
    sq_sh    = {sq_rem_r[17:0], sq_rad_r[SQ_W-1 -: 2]};
    sq_trial = {1'b0, sq_root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    off_u    = $signed({2'b0, pop_data.col}) - $signed({2'b0, cfg.width[SIDE_W-1:1]});
    off_v    = $signed({2'b0, pop_data.row}) - $signed({2'b0, cfg.height[SIDE_W-1:1]});
    mag_u    = off_u[13] ? 12'(-off_u) : off_u[11:0];
    mag_v    = off_v[13] ? 12'(-off_v) : off_v[11:0];
    q_s      = $signed(div_num_r[17:0]);
    uu       = u_r * u_r;
    vv       = v_r * v_r;
    r2       = {1'b0, u2_r} + {1'b0, v2_r};
    au       = u_r[17] ? 17'(-u_r) : u_r[16:0];
    av       = v_r[17] ? 17'(-v_r) : v_r[16:0];
    n_hyp    = (sq_root_r > HYP_CQ) ? sq_root_r - HYP_CQ : '0;
    om_u     = FX_ONE - u2_r;
    om_v     = FX_ONE - v2_r;
    diff     = 33'(job_r.height) - 33'(job_r.minimum);
    one_md   = $signed({2'b0, FX_ONE}) - $signed({2'b0, d_r});
    shifted  = prod_r >>> FRAC_BITS;
    blended  = 53'(shifted) + 53'(job_r.minimum);
    if (blended > 53'(HEIGHT_MAX))           sat_val = HEIGHT_MAX;
    else if (blended < -53'sd2147483648)     sat_val = 32'sh8000_0000;
    else                                     sat_val = blended[31:0];
  end

  assign pop_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; a new one loaded in S_SAT keeps valid high
      if (out_valid_r && out_ready && state_r != S_SAT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            job_r     <= pop_data;
            neg_u_r   <= off_u[13];
            neg_v_r   <= off_v[13];
            mag_v_r   <= mag_v;
            div_num_r <= {5'b0, mag_u, 17'b0};
            div_rem_r <= '0;
            div_den_r <= 16'(cfg.width);
            cnt_r     <= 6'(DIV_W);
            state_r   <= S_DIVU;
          end
        end
        S_DIVU: begin
          if (cnt_r != '0) begin
            div_num_r <= {div_num_r[DIV_W-2:0], div_ge};
            div_rem_r <= div_ge ? 16'(div_sh - {1'b0, div_den_r}) : div_sh[15:0];
            cnt_r     <= cnt_r - 1'b1;
          end else begin
            u_r       <= neg_u_r ? -q_s : q_s;
            div_num_r <= {5'b0, mag_v_r, 17'b0};
            div_rem_r <= '0;
            div_den_r <= 16'(cfg.height);
            cnt_r     <= 6'(DIV_W);
            state_r   <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (cnt_r != '0) begin
            div_num_r <= {div_num_r[DIV_W-2:0], div_ge};
            div_rem_r <= div_ge ? 16'(div_sh - {1'b0, div_den_r}) : div_sh[15:0];
            cnt_r     <= cnt_r - 1'b1;
          end else begin
            v_r     <= neg_v_r ? -q_s : q_s;
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          u2_r    <= uu[32:16];
          v2_r    <= vv[32:16];
          state_r <= S_DIST;
        end
        S_DIST: begin
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= 6'(SQ_STEPS);
          unique case (cfg.mode)
            MODE_BUMP: begin
              bump_r  <= om_u * om_v;
              state_r <= S_BUMP;
            end
            MODE_EUCL: begin
              sq_rad_r <= {1'b0, r2, 15'b0};
              state_r  <= S_ROOT;
            end
            MODE_SQR: begin
              d_r     <= r2[17:1];
              state_r <= S_MUL;
            end
            MODE_HYP: begin
              sq_rad_r <= {r2 + {1'b0, HYP_C2}, 16'b0};
              state_r  <= S_ROOT;
            end
            default: begin
              d_r     <= (au > av) ? au : av;
              state_r <= S_MUL;
            end
          endcase
        end
        S_BUMP: begin
          d_r     <= FX_ONE - bump_r[32:16];
          state_r <= S_MUL;
        end
        S_ROOT: begin
          if (cnt_r != '0) begin
            sq_rad_r  <= {sq_rad_r[SQ_W-3:0], 2'b00};
            sq_rem_r  <= sq_ge ? sq_sh - sq_trial : sq_sh;
            sq_root_r <= {sq_root_r[15:0], sq_ge};
            cnt_r     <= cnt_r - 1'b1;
          end else if (cfg.mode == MODE_EUCL) begin
            d_r     <= sq_root_r;
            state_r <= S_MUL;
          end else begin
            // division by the constant K as a reciprocal multiply
            hyp_prod_r <= n_hyp * HYP_RECIP;
            state_r    <= S_HYPQ;
          end
        end
        S_HYPQ: begin
          d_r     <= hyp_prod_r[49:33];
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= diff * one_md;
          state_r <= S_SAT;
        end
        S_SAT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_r.height_out <= sat_val;
            out_r.frame_end  <= job_r.last;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/island_falloff_shaper_unit.sv
// Island falloff shaper: scan requests are handled in the front end alone and give no result.
// A shape request goes through the one-bit-per-cycle divider (34 steps per division) and, by
// mode, the two-bits-per-cycle square root and a reciprocal multiply; one request at a time
// in the back.
// A four-entry queue lets scan and shape requests be accepted while the back end is busy.
// Reset is synchronous, active low: sizes 256 x 256, mode 0, minimum at the top of range.
module island_falloff_shaper_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifs_pkg::ifs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ifs_pkg::ifs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);
  import ifs_pkg::*;

  logic [SIDE_W-1:0] width_r, height_r;
  logic [2:0]        mode_r;
  ifs_cfg_t          cfg;
  logic              q_full, push_valid, pop_valid, pop_ready;
  ifs_job_t          push_data, pop_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd256;
      height_r <= 13'd256;
      mode_r   <= MODE_BUMP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_MODE:   mode_r   <= cfg_data[2:0];
        default:    ;
      endcase
    end
  end

  // clamp sizes to 1..MAX_SIDE, modes above diagonal act as diagonal
  always_comb begin
    cfg.width  = (width_r == '0) ? 13'd1 :
                 (width_r > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : width_r;
    cfg.height = (height_r == '0) ? 13'd1 :
                 (height_r > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : height_r;
    cfg.mode   = (mode_r > 3'(MODE_DIAG)) ? MODE_DIAG : dist_mode_t'(mode_r);
  end

  ifs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg,
    .q_full, .push_valid, .push_data
  );

  ifs_queue u_queue (
    .clk, .rst_n, .push_valid, .push_data, .full(q_full),
    .pop_valid, .pop_ready, .pop_data
  );

  ifs_back u_back (
    .clk, .rst_n, .cfg, .pop_valid, .pop_ready, .pop_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: src/ifs_checker.sv
// Port-level checks for the island falloff shaper, bound to the top level.
// Depends on ifs_pkg and island_falloff_shaper_unit.
module ifs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ifs_pkg::ifs_out_t out_data,
  input logic              cfg_ready
);
  import ifs_pkg::*;

  // result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // queue is empty after reset, so requests are taken
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind island_falloff_shaper_unit ifs_checker u_ifs_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data, .cfg_ready
);
